>>> sv/resistive_touch_press_detector_core_macros.svh
// Assertion macros for the touch press detector.
// Each macro takes a label, an antecedent, a consequent and a message.
// The clock is clk and the checks are off while rst_n is low.
`ifndef RESISTIVE_TOUCH_PRESS_DETECTOR_CORE_MACROS_SVH
`define RESISTIVE_TOUCH_PRESS_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent holds in the same cycle as the antecedent.
`define RTPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RTPD_ASSERT_SAME(lbl, ante, cons, msg)
`define RTPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/rtpd_pkg.sv
`default_nettype none

package rtpd_pkg;

  // Converter bits in use; at 16 the whole sample is kept
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_W     = 16;
  localparam int DOTS_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 16;

  // |sample - offset| * dots
  localparam int MAG_W     = CFG_W + DOTS_W;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_FULL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_FULL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd7;

  // Reset values
  localparam logic [CFG_W-1:0]  X_OFFSET_RST  = 16'd0;
  localparam logic [CFG_W-1:0]  X_FULL_RST    = 16'd65535;
  localparam logic [CFG_W-1:0]  Y_OFFSET_RST  = 16'd0;
  localparam logic [CFG_W-1:0]  Y_FULL_RST    = 16'd65535;
  localparam logic [DOTS_W-1:0] DISP_W_RST    = 12'd320;
  localparam logic [DOTS_W-1:0] DISP_H_RST    = 12'd240;
  localparam logic [CFG_W-1:0]  THRESHOLD_RST = 16'd40000;
  localparam logic [CFG_W-1:0]  WINDOW_RST    = 16'd100;
  localparam logic [CFG_W-1:0]  LAST_X_RST    = 16'd0;
  localparam logic [CFG_W-1:0]  LAST_Y_RST    = 16'd500;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input beat
    logic init;    // multiply and load the divider lanes
    logic step;    // one quotient bit per lane
    logic commit;  // update history and write the result register
  } rtpd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic accept;  // the captured scan starts a new press
  } rtpd_stat_t;

endpackage

`default_nettype wire

>>> sv/rtpd_div_lane.sv
`default_nettype none

module rtpd_div_lane (
  input  wire logic                            clk,
  input  wire logic                            init,
  input  wire logic                            step,
  input  wire logic [rtpd_pkg::MAG_W-1:0]      dvd_in,
  input  wire logic [rtpd_pkg::CFG_W-1:0]      dsr_in,
  input  wire logic                            neg_in,
  input  wire logic                            zero_in,
  output logic signed [rtpd_pkg::POS_W-1:0]    pos,
  output logic                                 zero
);

  localparam int MW = rtpd_pkg::MAG_W;
  localparam int RW = rtpd_pkg::CFG_W;
  localparam int PW = rtpd_pkg::POS_W;

  // Dividend shifts out at the top while quotient bits shift in at the bottom
  logic [MW-1:0] quo_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] dsr_r;
  logic          neg_r;
  logic          zero_r;

  logic [RW:0]   trial;
  logic [RW-1:0] diff;
  logic          fits;
  logic          sat_pos;
  logic          sat_neg;

  // When the divisor fits, the new remainder is below it and needs RW bits only
  assign trial = {rem_r, quo_r[MW-1]};
  assign diff  = trial[RW-1:0] - dsr_r;
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (init) begin
      quo_r  <= dvd_in;
      rem_r  <= '0;
      dsr_r  <= dsr_in;
      neg_r  <= neg_in;
      zero_r <= zero_in;
    end else if (step) begin
      quo_r <= {quo_r[MW-2:0], fits};
      rem_r <= fits ? diff : trial[RW-1:0];
    end
  end

  // Clamp the magnitude to the signed range of a position
  assign sat_pos = |quo_r[MW-1:PW-1];
  assign sat_neg = (|quo_r[MW-1:PW]) || (quo_r[PW-1] && (|quo_r[PW-2:0]));

  always_comb begin
    if (zero_r) begin
      pos = '0;
    end else if (neg_r) begin
      pos = sat_neg ? signed'({1'b1, {(PW-1){1'b0}}}) : signed'(-quo_r[PW-1:0]);
    end else begin
      pos = sat_pos ? signed'({1'b0, {(PW-1){1'b1}}}) : signed'(quo_r[PW-1:0]);
    end
  end

  assign zero = zero_r;

endmodule

`default_nettype wire

>>> sv/rtpd_dp.sv
`default_nettype none

module rtpd_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rtpd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [rtpd_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic [15:0]                         in_x_sample,
  input  wire logic [15:0]                         in_y_sample,
  input  wire rtpd_pkg::rtpd_cmd_t                 cmd,
  output rtpd_pkg::rtpd_stat_t                     st,
  output logic                                     out_press_pulse,
  output logic                                     out_press_held,
  output logic signed [rtpd_pkg::POS_W-1:0]        out_x_position,
  output logic signed [rtpd_pkg::POS_W-1:0]        out_y_position,
  output logic                                     out_range_fault
);

  localparam int CW = rtpd_pkg::CFG_W;
  localparam int DW = rtpd_pkg::DOTS_W;
  localparam int MW = rtpd_pkg::MAG_W;
  localparam int PW = rtpd_pkg::POS_W;
  localparam int SB = rtpd_pkg::SAMPLE_BITS;

  // Configuration registers
  logic [CW-1:0] x_off_r, x_full_r, y_off_r, y_full_r, thr_r, win_r;
  logic [DW-1:0] disp_w_r, disp_h_r;

  // Scan state
  logic [CW-1:0] xs_r, ys_r;
  logic [CW-1:0] last_x_r, last_y_r;
  logic          pressed_r;
  logic          pulse_r, fault_r;
  logic signed [PW-1:0] held_x_r, held_y_r;

  logic          touch;
  logic          near_x, near_y;
  logic          pressed_nxt;

  logic [CW:0]   dx, dy, rx, ry;
  logic [CW-1:0] dx_abs, dy_abs, rx_abs, ry_abs;
  logic [MW-1:0] mag_x, mag_y;

  logic signed [PW-1:0] lane_x_pos, lane_y_pos;
  logic                 lane_x_zero, lane_y_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r  <= rtpd_pkg::X_OFFSET_RST;
      x_full_r <= rtpd_pkg::X_FULL_RST;
      y_off_r  <= rtpd_pkg::Y_OFFSET_RST;
      y_full_r <= rtpd_pkg::Y_FULL_RST;
      disp_w_r <= rtpd_pkg::DISP_W_RST;
      disp_h_r <= rtpd_pkg::DISP_H_RST;
      thr_r    <= rtpd_pkg::THRESHOLD_RST;
      win_r    <= rtpd_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rtpd_pkg::CFG_X_OFFSET:  x_off_r  <= cfg_wdata;
        rtpd_pkg::CFG_X_FULL:    x_full_r <= cfg_wdata;
        rtpd_pkg::CFG_Y_OFFSET:  y_off_r  <= cfg_wdata;
        rtpd_pkg::CFG_Y_FULL:    y_full_r <= cfg_wdata;
        rtpd_pkg::CFG_DISP_W:    disp_w_r <= cfg_wdata[DW-1:0];
        rtpd_pkg::CFG_DISP_H:    disp_h_r <= cfg_wdata[DW-1:0];
        rtpd_pkg::CFG_THRESHOLD: thr_r    <= cfg_wdata;
        rtpd_pkg::CFG_WINDOW:    win_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture only the converter bits in use
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r <= CW'(in_x_sample[SB-1:0]);
      ys_r <= CW'(in_y_sample[SB-1:0]);
    end
  end

  // Touch and debounce decision
  assign touch  = (xs_r < thr_r) && (ys_r < thr_r);
  assign near_x = (({1'b0, xs_r} + {1'b0, win_r}) >= {1'b0, last_x_r}) &&
                  (({1'b0, last_x_r} + {1'b0, win_r}) >= {1'b0, xs_r});
  assign near_y = (({1'b0, ys_r} + {1'b0, win_r}) >= {1'b0, last_y_r}) &&
                  (({1'b0, last_y_r} + {1'b0, win_r}) >= {1'b0, ys_r});
  assign st.accept = touch && near_x && near_y && !pressed_r;
  assign pressed_nxt = touch && (pressed_r || st.accept);

  // Numerator magnitude and range for each axis
  assign dx = {1'b0, xs_r} - {1'b0, x_off_r};
  assign dy = {1'b0, ys_r} - {1'b0, y_off_r};
  assign rx = {1'b0, x_full_r} - {1'b0, x_off_r};
  assign ry = {1'b0, y_full_r} - {1'b0, y_off_r};

  assign dx_abs = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign dy_abs = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign rx_abs = rx[CW] ? CW'(-rx) : rx[CW-1:0];
  assign ry_abs = ry[CW] ? CW'(-ry) : ry[CW-1:0];

  assign mag_x = MW'(dx_abs) * MW'(disp_w_r);
  assign mag_y = MW'(dy_abs) * MW'(disp_h_r);

  rtpd_div_lane u_lane_x (
    .clk     (clk),
    .init    (cmd.init),
    .step    (cmd.step),
    .dvd_in  (mag_x),
    .dsr_in  (rx_abs),
    .neg_in  (dx[CW] ^ rx[CW]),
    .zero_in (rx == '0),
    .pos     (lane_x_pos),
    .zero    (lane_x_zero)
  );

  rtpd_div_lane u_lane_y (
    .clk     (clk),
    .init    (cmd.init),
    .step    (cmd.step),
    .dvd_in  (mag_y),
    .dsr_in  (ry_abs),
    .neg_in  (dy[CW] ^ ry[CW]),
    .zero_in (ry == '0),
    .pos     (lane_y_pos),
    .zero    (lane_y_zero)
  );

  // History and held positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r  <= rtpd_pkg::LAST_X_RST;
      last_y_r  <= rtpd_pkg::LAST_Y_RST;
      pressed_r <= 1'b0;
      held_x_r  <= '0;
      held_y_r  <= '0;
    end else if (cmd.commit) begin
      last_x_r  <= xs_r;
      last_y_r  <= ys_r;
      pressed_r <= pressed_nxt;
      if (st.accept) begin
        held_x_r <= lane_x_pos;
        held_y_r <= lane_y_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pulse_r <= st.accept;
      fault_r <= st.accept && (lane_x_zero || lane_y_zero);
    end
  end

  assign out_press_pulse = pulse_r;
  assign out_press_held  = pressed_r;
  assign out_x_position  = held_x_r;
  assign out_y_position  = held_y_r;
  assign out_range_fault = fault_r;

endmodule

`default_nettype wire

>>> sv/rtpd_ctrl.sv
`default_nettype none

module rtpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire rtpd_pkg::rtpd_stat_t  st,
  output rtpd_pkg::rtpd_cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam int CNW = rtpd_pkg::CNT_W;

  logic [2:0]     state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = st.accept ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cmd.init  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNW'(rtpd_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/resistive_touch_press_detector_core.sv
// Order of work: a scan that starts no press is captured, evaluated and then written,
//   a scan that starts a press also multiplies, then takes 28 restoring divide steps.
// Flow: one scan at a time; the write of a result waits while the last one is stalled.
//   The X and Y divider lanes run side by side, one quotient bit per cycle.
// Reset (rst_n low, synchronous): registers to their defaults, history to X 0 / Y 500,
//   press latch and held positions cleared, no result pending.
`default_nettype none

`include "resistive_touch_press_detector_core_macros.svh"

module resistive_touch_press_detector_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [rtpd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [rtpd_pkg::CFG_W-1:0]          cfg_wdata,
  // scan beats
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [15:0]                         in_x_sample,
  input  wire logic [15:0]                         in_y_sample,
  // result beats
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_press_pulse,
  output logic                                     out_press_held,
  output logic signed [rtpd_pkg::POS_W-1:0]        out_x_position,
  output logic signed [rtpd_pkg::POS_W-1:0]        out_y_position,
  output logic                                     out_range_fault
);

  rtpd_pkg::rtpd_cmd_t  cmd;
  rtpd_pkg::rtpd_stat_t st;

  // Sequencer: capture, decide, multiply, divide, then write the result register.
  // The result register parts the two sides; a new beat is taken once the
  // previous result is written, even while it still waits downstream.
  rtpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Configuration, debounce history, press latch, calibration arithmetic
  // and the held result payload.
  rtpd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_x_sample     (in_x_sample),
    .in_y_sample     (in_y_sample),
    .cmd             (cmd),
    .st              (st),
    .out_press_pulse (out_press_pulse),
    .out_press_held  (out_press_held),
    .out_x_position  (out_x_position),
    .out_y_position  (out_y_position),
    .out_range_fault (out_range_fault)
  );

  // A press pulse always comes with the press latched
  `RTPD_ASSERT_SAME(a_pulse_held, out_valid, !out_press_pulse || out_press_held, "pulse without held press")
  // A range fault is reported only on the scan that accepts a press
  `RTPD_ASSERT_SAME(a_fault_pulse, out_valid && out_range_fault, out_press_pulse, "fault without pulse")
  // One scan at a time: a taken beat closes the input side
  `RTPD_ASSERT_NEXT(a_one_scan, in_valid && !in_stall, in_stall, "input open after beat")
  // A commit never overwrites a result still waiting downstream
  `RTPD_ASSERT_SAME(a_no_overwrite, cmd.commit, !out_valid || !out_stall, "pending result lost")

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpd_pkg::*;

  localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 1);

  // One scan as presented on the input channel
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } scan_t;

  // One report as seen on the result channel
  typedef struct packed {
    logic               pulse;
    logic               held;
    logic signed [15:0] xpos;
    logic signed [15:0] ypos;
    logic               fault;
  } touch_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_X_OFFSET;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_x_sample = '0;
  logic [15:0] in_y_sample = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_press_pulse;
  logic               out_press_held;
  logic signed [15:0] out_x_position;
  logic signed [15:0] out_y_position;
  logic               out_range_fault;

  resistive_touch_press_detector_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_sample     (in_x_sample),
    .in_y_sample     (in_y_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_press_pulse (out_press_pulse),
    .out_press_held  (out_press_held),
    .out_x_position  (out_x_position),
    .out_y_position  (out_y_position),
    .out_range_fault (out_range_fault)
  );

  // Scans waiting for the driver, and reports the block still owes us
  scan_t         scans_to_send[$];
  touch_report_t reports_due[$];

  // Our own copy of the calibration registers
  logic [15:0] xoff_q = X_OFFSET_RST;
  logic [15:0] xfull_q = X_FULL_RST;
  logic [15:0] yoff_q = Y_OFFSET_RST;
  logic [15:0] yfull_q = Y_FULL_RST;
  logic [11:0] dotw_q = DISP_W_RST;
  logic [11:0] doth_q = DISP_H_RST;
  logic [15:0] thr_q = THRESHOLD_RST;
  logic [15:0] win_q = WINDOW_RST;

  // Our own copy of the scan history, press latch and held positions
  logic [15:0]        prev_x = LAST_X_RST;
  logic [15:0]        prev_y = LAST_Y_RST;
  logic               latched = 1'b0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;

  int idle_pct = 30;
  int scans_queued = 0;
  int scans_sent = 0;
  int results_seen = 0;
  int presses_seen = 0;
  int faults_seen = 0;
  int setups_applied = 0;
  int fail_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Calibrate one axis: (sample - offset) * dots / (full - offset), truncated
  // toward zero and clamped to 16-bit signed; a zero span yields 0 and a fault.
  function automatic logic signed [15:0] scale_axis(input longint smp, input longint off,
                                                    input longint full, input longint dots,
                                                    output logic zero_span);
    longint span;
    longint prod;
    longint q;
    span = full - off;
    prod = (smp - off) * dots;
    zero_span = (span == 0);
    if (zero_span) return '0;
    q = prod / span;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bit within_window(input longint now_s, input longint prev_s);
    return (now_s + win_q) >= prev_s && (prev_s + win_q) >= now_s;
  endfunction

  // Advance the press detector by one scan and return the report it produces
  function automatic touch_report_t predict_scan(input logic [15:0] x_raw, input logic [15:0] y_raw);
    logic [15:0]   xs;
    logic [15:0]   ys;
    logic          fx;
    logic          fy;
    touch_report_t r;
    xs = x_raw & SAMPLE_MASK;
    ys = y_raw & SAMPLE_MASK;
    r.pulse = 1'b0;
    r.fault = 1'b0;
    if (xs < thr_q && ys < thr_q) begin
      // a touch starts a press only when steady on both axes and nothing is latched
      if (within_window(longint'(xs), longint'(prev_x)) &&
          within_window(longint'(ys), longint'(prev_y)) && !latched) begin
        pos_x = scale_axis(longint'(xs), longint'(xoff_q), longint'(xfull_q),
                           longint'(dotw_q), fx);
        pos_y = scale_axis(longint'(ys), longint'(yoff_q), longint'(yfull_q),
                           longint'(doth_q), fy);
        r.fault = fx | fy;
        r.pulse = 1'b1;
        latched = 1'b1;
      end
    end else begin
      latched = 1'b0;
    end
    prev_x = xs;
    prev_y = ys;
    r.held = latched;
    r.xpos = pos_x;
    r.ypos = pos_y;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued scans, idling at random, and predict each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reports_due.push_back(predict_scan(in_x_sample, in_y_sample));
        scans_sent++;
      end
      // hold a stalled beat; otherwise load the next one or drop valid
      if (!in_valid || !in_stall) begin
        if (scans_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid    <= 1'b1;
          in_x_sample <= scans_to_send[0].x;
          in_y_sample <= scans_to_send[0].y;
          void'(scans_to_send.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, check every accepted result beat
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch at result %0d: %s got %0d, expected %0d",
               results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    touch_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch("result beat with no scan pending", 1, 0);
        end else begin
          want = reports_due.pop_front();
          if (out_press_pulse !== want.pulse)
            report_mismatch("press_pulse", longint'(out_press_pulse), longint'(want.pulse));
          if (out_press_held !== want.held)
            report_mismatch("press_held", longint'(out_press_held), longint'(want.held));
          if (out_x_position !== want.xpos)
            report_mismatch("x_position", longint'(out_x_position), longint'(want.xpos));
          if (out_y_position !== want.ypos)
            report_mismatch("y_position", longint'(out_y_position), longint'(want.ypos));
          if (out_range_fault !== want.fault)
            report_mismatch("range_fault", longint'(out_range_fault), longint'(want.fault));
          if (want.pulse) presses_seen++;
          if (want.fault) faults_seen++;
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_scan(input logic [15:0] x, input logic [15:0] y);
    scan_t s;
    s.x = x;
    s.y = y;
    scans_to_send.push_back(s);
    scans_queued++;
  endtask

  // Write one register at the next edge and track it in our copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_X_OFFSET:  xoff_q = val;
      CFG_X_FULL:    xfull_q = val;
      CFG_Y_OFFSET:  yoff_q = val;
      CFG_Y_FULL:    yfull_q = val;
      CFG_DISP_W:    dotw_q = val[11:0];
      CFG_DISP_H:    doth_q = val[11:0];
      CFG_THRESHOLD: thr_q = val;
      CFG_WINDOW:    win_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [15:0] xo, input logic [15:0] xf,
                             input logic [15:0] yo, input logic [15:0] yf,
                             input logic [15:0] dw, input logic [15:0] dh,
                             input logic [15:0] thr, input logic [15:0] win);
    write_reg(CFG_X_OFFSET, xo);
    write_reg(CFG_X_FULL, xf);
    write_reg(CFG_Y_OFFSET, yo);
    write_reg(CFG_Y_FULL, yf);
    write_reg(CFG_DISP_W, dw);
    write_reg(CFG_DISP_H, dh);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WINDOW, win);
    @(posedge clk);
    cfg_we <= 1'b0;
    setups_applied++;
    @(negedge clk);
  endtask

  // Wait until every scan is accepted and every report has come back
  task automatic wait_drain();
    do @(negedge clk);
    while (scans_to_send.size() != 0 || in_valid || reports_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_setup();
    logic [15:0] xo, xf, yo, yf, thr, win;
    case ($urandom_range(0, 3))
      0: begin
        // plausible panel: small offsets, full scale near the top
        xo = 16'($urandom_range(0, 8000));
        xf = 16'($urandom_range(56000, 65535));
        yo = 16'($urandom_range(0, 8000));
        yf = 16'($urandom_range(56000, 65535));
        thr = 16'($urandom_range(30000, 65535));
        win = 16'($urandom_range(20, 400));
      end
      1: begin
        // mirrored axes: full below offset
        xo = 16'($urandom_range(56000, 65535));
        xf = 16'($urandom_range(0, 8000));
        yo = 16'($urandom_range(56000, 65535));
        yf = 16'($urandom_range(0, 8000));
        thr = 16'($urandom_range(30000, 65535));
        win = 16'($urandom_range(0, 1000));
      end
      2: begin
        // anything goes, often with a collapsed span
        xo = 16'($urandom);
        xf = ($urandom_range(0, 2) == 0) ? xo : 16'($urandom);
        yo = 16'($urandom);
        yf = ($urandom_range(0, 2) == 0) ? yo : 16'($urandom);
        thr = 16'($urandom);
        win = 16'($urandom);
      end
      default: begin
        // narrow spans, so quotients saturate
        xo = 16'($urandom_range(0, 60000));
        xf = xo + 16'($urandom_range(0, 3));
        yo = 16'($urandom_range(0, 60000));
        yf = yo - 16'($urandom_range(0, 3));
        thr = 16'($urandom_range(40000, 65535));
        win = 16'($urandom_range(0, 5));
      end
    endcase
    // upper nibble of the dot counts is junk the block must drop
    apply_setup(xo, xf, yo, yf, 16'($urandom), 16'($urandom), thr, win);
  endtask

  // Step a sample by up to the window, now and then just past it
  function automatic int nudge(input int base, input int w, input int top);
    int v;
    v = base + int'($urandom_range(0, 2 * w)) - w;
    if ($urandom_range(0, 9) == 0)
      v = ($urandom_range(0, 1) != 0) ? base + w + 1 : base - w - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  // Mostly lift, land, settle; the rest is noise
  task automatic add_gesture();
    int top, hx, hy, n;
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 2))
        0: queue_scan(16'($urandom), 16'($urandom));
        1: queue_scan(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
        default: queue_scan(($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom));
      endcase
      return;
    end
    top = int'(thr_q) - 1;
    queue_scan(16'($urandom_range(int'(thr_q), 65535)), 16'($urandom));
    if (top < 0) return;
    hx = $urandom_range(0, top);
    hy = $urandom_range(0, top);
    queue_scan(16'(hx), 16'(hy));
    n = $urandom_range(1, 5);
    repeat (n) begin
      hx = nudge(hx, int'(win_q), top);
      hy = nudge(hy, int'(win_q), top);
      queue_scan(16'(hx), 16'(hy));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setup: history starts at X 0 / Y 500, so a steady first touch is taken
    queue_scan(16'd0, 16'd500);
    queue_scan(16'd50, 16'd550);       // touch while latched: no pulse, positions kept
    queue_scan(16'hFFFF, 16'hFFFF);    // release
    queue_scan(16'd39999, 16'd39999);  // touch, but jumped too far
    queue_scan(16'd39899, 16'd39950);  // steady now: press
    queue_scan(16'd39899, 16'd39950);
    queue_scan(16'd40000, 16'd100);    // sample equal to threshold is no touch
    queue_scan(16'd39900, 16'd150);    // within window of the release scan
    queue_scan(16'hAAAA, 16'h5555);
    queue_scan(16'h5555, 16'hAAAA);
    wait_drain();

    // Span of +1 on X and -1 on Y with widest display: saturate both ways
    apply_setup(16'd1000, 16'd1001, 16'd65535, 16'd65534, 16'd4095, 16'd4095,
                16'd65535, 16'd65535);
    queue_scan(16'd65535, 16'd0);
    queue_scan(16'd60000, 16'd0);
    queue_scan(16'd65535, 16'd65535);
    queue_scan(16'd0, 16'd65534);
    queue_scan(16'd65535, 16'd65535);
    wait_drain();

    // Collapsed X span, zero display width, threshold 1, no jitter allowed
    apply_setup(16'd12345, 16'd12345, 16'd0, 16'd65535, 16'hF000, 16'd4095,
                16'd1, 16'd0);
    queue_scan(16'd0, 16'd0);
    queue_scan(16'd0, 16'd0);
    queue_scan(16'd1, 16'd0);
    queue_scan(16'd0, 16'd0);
    queue_scan(16'd0, 16'd0);
    wait_drain();

    // Threshold 0: nothing can ever count as a touch
    apply_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'd320, 16'd240, 16'd0, 16'd65535);
    queue_scan(16'd0, 16'd0);
    queue_scan(16'hFFFF, 16'd0);
    wait_drain();

    // Random phases; the third runs with no idling on either side,
    // the last goes back to the reset values
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        apply_setup(X_OFFSET_RST, X_FULL_RST, Y_OFFSET_RST, Y_FULL_RST,
                    16'(DISP_W_RST), 16'(DISP_H_RST), THRESHOLD_RST, WINDOW_RST);
      else
        random_setup();
      idle_pct = (ph == 2) ? 0 : 30;
      target = scans_queued + 255;
      while (scans_queued < target) add_gesture();
      wait_drain();
    end

    // Let any stray beat show itself
    repeat (40) @(negedge clk);
    if (reports_due.size() != 0)
      report_mismatch("reports never delivered", 0, reports_due.size());

    $display("Run covered %0d scans and %0d result beats over %0d register setups;",
             scans_sent, results_seen, setups_applied);
    $display("%0d presses were accepted, %0d of them against a zero calibration span.",
             presses_seen, faults_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/rtpd_pkg.sv
sv/rtpd_div_lane.sv
sv/rtpd_dp.sv
sv/rtpd_ctrl.sv
sv/resistive_touch_press_detector_core.sv
dv/tb.sv
